// ===== hdl/dcache_timing_model_defines.svh =====
// Assertion macros shared by the cache timing model.
`ifndef DCACHE_TIMING_MODEL_DEFINES_SVH
`define DCACHE_TIMING_MODEL_DEFINES_SVH

// Assert that a condition implies another in the same cycle.
`define DCTM_ASSERT_IMP(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Assert that a condition implies another in the next cycle.
`define DCTM_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== hdl/dctm_pkg.sv =====
`default_nettype none
package dctm_pkg;
  localparam int WAYS        = 8;
  localparam int SETS        = 256;
  localparam int STORE_SLOTS = 8;
  localparam int SLOT_W      = $clog2(STORE_SLOTS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int SET_W       = $clog2(SETS);
  localparam int TAG_W       = 20;
  localparam int LINE_W      = 28;
  localparam int UNTIL_W     = 33;
  localparam int DELAY_W     = 10;
  localparam int SUM_W       = 34;
  localparam logic [SUM_W-1:0] DELAY_MAX = SUM_W'(1023);
  localparam logic [7:0] LFSR_TAPS  = 8'hFA;
  localparam logic [7:0] LFSR_RESET = 8'hFF;
  localparam logic [7:0] MEM_LAT_RESET = 8'd20;
  localparam logic [7:0] HIT_LAT_RESET = 8'd1;
  localparam logic [0:0] REG_MEM_LAT = 1'b0;
  localparam logic [0:0] REG_HIT_LAT = 1'b1;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted item, run pending-store search
    logic lookup;   // tag read data is valid: compute and update
    logic emit;     // result register loaded
  } dctm_cmd_t;

  typedef struct packed {
    logic is_store;
    logic clearing;  // valid-bit memory is being swept after reset
  } dctm_status_t;
endpackage
`default_nettype wire

// ===== hdl/dctm_if.sv =====
`default_nettype none
interface dctm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] address;
  logic [31:0] issue_cycle;
  modport source (output valid, opcode, address, issue_cycle, input ready);
  modport sink (input valid, opcode, address, issue_cycle, output ready);
endinterface

interface dctm_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] delay;
  logic       miss;
  modport source (output valid, delay, miss, input ready);
  modport sink (input valid, delay, miss, output ready);
endinterface
`default_nettype wire

// ===== hdl/dctm_ctrl.sv =====
`default_nettype none
`include "dcache_timing_model_defines.svh"
module dctm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire dctm_pkg::dctm_status_t status,
  output dctm_pkg::dctm_cmd_t        cmd
);
  import dctm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   busy;

  assign busy     = (state != ST_IDLE);
  // One item at a time; a new item may enter while the previous result waits
  // only if that result leaves this cycle or has already left. Nothing enters
  // while the valid bits are still being swept after reset.
  assign in_ready = !busy && !status.clearing && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.lookup     = 1'b1;
        cmd.emit       = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `DCTM_ASSERT_NEXT(a_cap_look, clk, rst, cmd.capture, state == ST_LOOK, "capture must go to lookup")
  `DCTM_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid, "emit must raise out_valid")
  `DCTM_ASSERT_IMP(a_no_overrun, clk, rst, cmd.emit, !out_valid, "emit over held result")
  `DCTM_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == ST_IDLE, "ready only when idle")
  `DCTM_ASSERT_IMP(a_no_ready_clear, clk, rst, status.clearing, !in_ready, "ready during sweep")
endmodule
`default_nettype wire

// ===== hdl/dctm_dp.sv =====
`default_nettype none
`include "dcache_timing_model_defines.svh"
module dctm_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dctm_pkg::dctm_cmd_t   cmd,
  output dctm_pkg::dctm_status_t     status,
  input  wire logic                  in_opcode,
  input  wire logic [31:0]           in_address,
  input  wire logic [31:0]           in_issue_cycle,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [7:0]            cfg_data,
  output logic [dctm_pkg::DELAY_W-1:0] delay,
  output logic                       miss
);
  import dctm_pkg::*;

  logic [7:0] mem_lat, hit_lat;
  logic       op;
  logic [31:0] addr;
  logic [31:0] now;
  logic [7:0]  lfsr;
  logic        miss_flag;

  // Tag and valid memories: one row per set holds all ways. The valid rows
  // are swept to zero by a pass of one set per cycle after reset.
  logic [WAYS*TAG_W-1:0] tag_mem [SETS];
  logic [WAYS*TAG_W-1:0] tag_row;
  logic [WAYS-1:0]       valid_mem [SETS];
  logic [WAYS-1:0]       valid_row;
  logic [SET_W:0]        clr_cnt;
  logic                  clearing;

  logic [LINE_W-1:0]  pline  [STORE_SLOTS];
  logic [UNTIL_W-1:0] puntil [STORE_SLOTS];
  logic [STORE_SLOTS-1:0] pvalid;
  logic [SLOT_W-1:0]  age [STORE_SLOTS];  // 0 = oldest slot, valid or not

  logic [SET_W-1:0]   set_idx;
  logic [LINE_W-1:0]  line;
  logic [TAG_W-1:0]   tag;
  assign set_idx = addr[11:4];
  assign line    = addr[31:4];
  assign tag     = addr[31:12];
  assign clearing = !clr_cnt[SET_W];
  assign status.is_store = op;
  assign status.clearing = clearing;

  // Pending search result, registered in the lookup state.
  logic               pm_hit;
  logic [SLOT_W-1:0]  pm_slot;
  logic [UNTIL_W-1:0] pm_until;
  logic               pf_any;
  logic [SLOT_W-1:0]  pf_slot;
  logic [SLOT_W-1:0]  po_slot;
  logic               hit_r;
  logic [SLOT_W-1:0]  hit_slot_r, free_slot_r, old_slot_r;
  logic               free_r;
  logic [UNTIL_W-1:0] until_r;

  always_comb begin
    pm_hit = 1'b0; pm_slot = '0; pm_until = '0;
    pf_any = 1'b0; pf_slot = '0; po_slot = '0;
    for (int i = STORE_SLOTS-1; i >= 0; i--) begin
      if (pvalid[i] && pline[i] == line) begin
        pm_hit = 1'b1; pm_slot = SLOT_W'(i); pm_until = puntil[i];
      end
      if (!pvalid[i]) begin
        pf_any = 1'b1; pf_slot = SLOT_W'(i);
      end
      if (age[i] == '0) po_slot = SLOT_W'(i);
    end
  end

  logic [WAYS-1:0] way_hit;
  logic            tag_hit;
  logic [7:0]      lfsr_step;
  logic [WAY_W-1:0] vic;
  logic            cacheable;
  logic [UNTIL_W-1:0] block;
  logic [SUM_W-1:0] sum;

  always_comb begin
    for (int w = 0; w < WAYS; w++)
      way_hit[w] = valid_row[w] && tag_row[w*TAG_W +: TAG_W] == tag;
    tag_hit   = |way_hit;
    lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
    vic       = lfsr_step[WAY_W-1:0];
    cacheable = addr[31:30] == 2'b10;
    block     = (hit_r && {1'b0, now} < until_r) ? until_r - {1'b0, now} : '0;
    if (op == OP_STORE) sum = SUM_W'(2);
    else if (!cacheable) sum = SUM_W'(mem_lat) + SUM_W'(3) + SUM_W'(block);
    else if (tag_hit) sum = SUM_W'(hit_lat) + SUM_W'(block);
    else sum = SUM_W'(mem_lat) + SUM_W'(block);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_opcode; addr <= in_address; now <= in_issue_cycle;
    end
    tag_row   <= tag_mem[set_idx];
    valid_row <= valid_mem[set_idx];
    hit_r <= pm_hit; hit_slot_r <= pm_slot; until_r <= pm_until;
    free_r <= pf_any; free_slot_r <= pf_slot; old_slot_r <= po_slot;
    if (cmd.lookup && op == OP_LOAD && cacheable && !tag_hit)
      tag_mem[set_idx][vic*TAG_W +: TAG_W] <= tag;
    if (clearing)
      valid_mem[clr_cnt[SET_W-1:0]] <= '0;
    else if (cmd.lookup && op == OP_LOAD && cacheable && !tag_hit)
      valid_mem[set_idx][vic] <= 1'b1;
    if (cmd.emit) begin
      delay <= (sum > DELAY_MAX) ? DELAY_W'(1023) : sum[DELAY_W-1:0];
    end
    if (cmd.lookup && op == OP_STORE) begin
      pline[hit_r ? hit_slot_r : free_r ? free_slot_r : old_slot_r]  <= line;
      puntil[hit_r ? hit_slot_r : free_r ? free_slot_r : old_slot_r] <= {1'b0, now} + 33'd5;
    end
  end

  logic [SLOT_W-1:0] wslot;
  assign wslot = hit_r ? hit_slot_r : free_r ? free_slot_r : old_slot_r;
  assign miss  = miss_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_lat <= MEM_LAT_RESET; hit_lat <= HIT_LAT_RESET;
      lfsr <= LFSR_RESET; miss_flag <= 1'b0; pvalid <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < STORE_SLOTS; i++) age[i] <= SLOT_W'(i);
    end else begin
      if (clearing) clr_cnt <= clr_cnt + (SET_W+1)'(1);
      if (cfg_we && cfg_index == REG_MEM_LAT) mem_lat <= cfg_data;
      if (cfg_we && cfg_index == REG_HIT_LAT) hit_lat <= cfg_data;
      if (cmd.lookup) begin
        if (op == OP_STORE) begin
          pvalid[wslot] <= 1'b1;
          // Written slot becomes newest; younger ones shift down by one.
          for (int i = 0; i < STORE_SLOTS; i++)
            if (i == int'(wslot)) age[i] <= SLOT_W'(STORE_SLOTS-1);
            else if (age[i] > age[wslot]) age[i] <= age[i] - SLOT_W'(1);
        end else begin
          if (hit_r) pvalid[hit_slot_r] <= 1'b0;
          if (!cacheable) miss_flag <= 1'b1;
          else if (tag_hit) miss_flag <= 1'b0;
          else begin
            miss_flag <= 1'b1;
            lfsr <= lfsr_step;
          end
        end
      end
    end
  end

  `DCTM_ASSERT_NEXT(a_store_valid, clk, rst, cmd.lookup && op == OP_STORE, pvalid[$past(wslot)], "store slot not valid")
  `DCTM_ASSERT_NEXT(a_store_delay, clk, rst, cmd.emit && op == OP_STORE, delay == DELAY_W'(2), "store delay wrong")
  `DCTM_ASSERT_IMP(a_hit_onehot, clk, rst, cmd.lookup, $onehot0(way_hit), "way hit")
endmodule
`default_nettype wire

// ===== hdl/dcache_timing_model.sv =====
`default_nettype none
// Channel | Dir | Payload
// req     | in  | opcode, address, issue_cycle
// rsp     | out | delay, miss
// cfg     | in  | cfg_we, cfg_index, cfg_data (plain write port)
//
// An accepted item goes first through the registered tag-row and pending-store
// reads, then through a step that computes the delay and updates the tag
// memory, LFSR and pending table. No new item is accepted while one is still
// in those steps. Reset is synchronous; after it a pass sweeps the valid bits,
// one set per cycle, and no item is accepted until the pass ends.
// A held result blocks the next item until it is taken; both may move in
// the same cycle.
module dcache_timing_model (
  input  wire logic       clk,
  input  wire logic       rst,
  dctm_req_if.sink        req,
  dctm_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import dctm_pkg::*;

  dctm_cmd_t    cmd;
  dctm_status_t status;

  // The controller sequences each item through capture, read and compute.
  dctm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(status), .cmd(cmd)
  );

  // The datapath holds the tag memory, pending stores and result register.
  dctm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_opcode(req.opcode), .in_address(req.address),
    .in_issue_cycle(req.issue_cycle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .delay(rsp.delay), .miss(rsp.miss)
  );
endmodule
`default_nettype wire

// ===== bench/dcache_timing_model_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module dcache_timing_model_checker (
  input  wire logic clk,
  input  wire logic rst,
  dctm_req_if.sink  req_mon,
  dctm_rsp_if.sink  rsp_mon,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output int        errors,
  output int        pending_results,
  output logic      accepted
);
  import dctm_pkg::*;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               miss;
  } access_cost_t;

  logic [7:0]         mem_lat, hit_lat;
  logic [TAG_W-1:0]   tags [WAYS*SETS];
  logic               tag_valid [WAYS*SETS];
  logic [7:0]         lfsr;
  logic               miss_q;
  logic [LINE_W-1:0]  blk_line [STORE_SLOTS];
  logic [UNTIL_W-1:0] blk_until [STORE_SLOTS];
  logic               blk_valid [STORE_SLOTS];
  longint unsigned    blk_age [STORE_SLOTS];
  longint unsigned    age_ctr;
  access_cost_t       cost_q [$];

  assign pending_results = cost_q.size();
  assign accepted = (req_mon.valid && req_mon.ready) || (rsp_mon.valid && rsp_mon.ready);

  function automatic access_cost_t cost_of_access(logic op, logic [31:0] addr,
                                                  logic [31:0] now);
    access_cost_t        r;
    logic [LINE_W-1:0]   line;
    logic [SET_W-1:0]    set;
    logic [TAG_W-1:0]    tag;
    longint unsigned     sum;
    longint unsigned     blk;
    int                  slot;
    bit                  hit;
    int                  w;
    line = addr[31:4];
    set  = addr[11:4];
    tag  = addr[31:12];
    blk  = 0;
    if (op == OP_STORE) begin
      slot = -1;
      for (int i = 0; i < STORE_SLOTS; i++)
        if (slot < 0 && blk_valid[i] && blk_line[i] == line) slot = i;
      for (int i = 0; i < STORE_SLOTS; i++)
        if (slot < 0 && !blk_valid[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < STORE_SLOTS; i++)
          if (blk_age[i] < blk_age[slot]) slot = i;
      end
      blk_line[slot]  = line;
      blk_until[slot] = {1'b0, now} + 33'd5;
      blk_valid[slot] = 1'b1;
      blk_age[slot]   = age_ctr++;
      sum = 2;
    end else begin
      for (int i = 0; i < STORE_SLOTS; i++)
        if (blk_valid[i] && blk_line[i] == line) begin
          if ({1'b0, now} < blk_until[i]) blk = blk_until[i] - {1'b0, now};
          blk_valid[i] = 1'b0;
          break;
        end
      if (!(addr >= 32'h8000_0000 && addr < 32'hC000_0000)) begin
        miss_q = 1'b1;
        sum = mem_lat + 3 + blk;
      end else begin
        hit = 0;
        for (int i = 0; i < WAYS; i++)
          if (tag_valid[i*SETS+set] && tags[i*SETS+set] == tag) hit = 1;
        if (hit) begin
          miss_q = 1'b0;
          sum = hit_lat + blk;
        end else begin
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
          w = lfsr & 8'h7;
          tags[w*SETS+set] = tag;
          tag_valid[w*SETS+set] = 1'b1;
          miss_q = 1'b1;
          sum = mem_lat + blk;
        end
      end
    end
    if (sum > 1023) sum = 1023;
    r.delay = sum[DELAY_W-1:0];
    r.miss  = miss_q;
    return r;
  endfunction

  always @(posedge clk) begin
    access_cost_t want;
    if (rst) begin
      mem_lat = MEM_LAT_RESET;
      hit_lat = HIT_LAT_RESET;
      lfsr    = LFSR_RESET;
      miss_q  = 1'b0;
      age_ctr = 0;
      errors  = 0;
      for (int i = 0; i < WAYS*SETS; i++) tag_valid[i] = 1'b0;
      for (int i = 0; i < STORE_SLOTS; i++) begin
        blk_valid[i] = 1'b0;
        blk_age[i] = 0;
      end
      cost_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MEM_LAT) mem_lat = cfg_data;
        else hit_lat = cfg_data;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (cost_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result delay=%0d miss=%0b",
                                     rsp_mon.delay, rsp_mon.miss);
        end else begin
          want = cost_q.pop_front();
          if (want.delay !== rsp_mon.delay || want.miss !== rsp_mon.miss) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected delay=%0d miss=%0b, got delay=%0d miss=%0b",
                       want.delay, want.miss, rsp_mon.delay, rsp_mon.miss);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        cost_q.push_back(cost_of_access(req_mon.opcode, req_mon.address,
                                        req_mon.issue_cycle));
    end
  end
endmodule
`default_nettype wire

// ===== bench/dcache_timing_model_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module dcache_timing_model_tb;
  import dctm_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_MEM_LAT;
  logic [7:0] cfg_data = '0;
  int         errors;
  int         pending_results;
  logic       accepted;
  int         idle_cycles = 0;
  bit         sink_hold = 0;
  bit         sink_free = 0;
  logic [31:0] clock_now = 32'd0;

  dctm_req_if req ();
  dctm_rsp_if rsp ();

  always #2 clk = ~clk;

  dcache_timing_model u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dcache_timing_model_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req.sink), .rsp_mon(rsp.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending_results(pending_results), .accepted(accepted)
  );

  // Watchdog: the run ends if nothing moves on either channel for too long.
  // The longest legal quiet spells are the valid-bit sweep after reset and the deliberate receiver hold-off.
  always @(posedge clk) begin
    if (rst || accepted) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Random gap length: mostly short, occasionally long.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Receiver. It stalls randomly, and holds off for a long stretch on request
  // so the block fills up and pushes back on its input.
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold) begin
        rsp.ready = 1'b0;
        repeat (200) @(negedge clk);
        sink_hold = 0;
      end
      n = sink_free ? 0 : gap_len();
      if (n > 0) begin
        rsp.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp.ready = 1'b1;
      @(negedge clk);
    end
  end

  // Drives one item and waits for its acceptance. The item carries clock_now as
  // its issue cycle; the test moves it between items, sometimes inside a store block.
  task automatic send_access(logic op, logic [31:0] addr);
    int n;
    n = sink_free ? 0 : gap_len();
    if (n > 0) begin
      req.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    req.valid       = 1'b1;
    req.opcode      = op;
    req.address     = addr;
    req.issue_cycle = clock_now;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic next_cycle(int step);
    clock_now = clock_now + step;
  endtask

  task automatic drain();
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Picks a cacheable address, mostly from a few sets so that lines collide,
  // evict each other and get reused.
  function automatic logic [31:0] cached_addr();
    logic [31:0] a;
    a = {2'b10, 30'($urandom)};
    if ($urandom_range(0, 3) != 0) begin
      a[11:4]  = 8'($urandom_range(0, 3));
      a[29:12] = 18'($urandom_range(0, 11));
    end
    return a;
  endfunction

  function automatic logic [31:0] any_addr();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {2'b0, 30'($urandom)};
      default: return cached_addr();
    endcase
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] lines [4];
    req.valid       = 1'b0;
    req.opcode      = OP_LOAD;
    req.address     = '0;
    req.issue_cycle = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset latencies, extremes of the address range, every
    // operation, blocks both pending and already over, and uncached stores.
    send_access(OP_LOAD, 32'h8000_0000);
    send_access(OP_LOAD, 32'h8000_0000);
    send_access(OP_LOAD, 32'hBFFF_FFFF);
    send_access(OP_LOAD, 32'hC000_0000);
    send_access(OP_LOAD, 32'h7FFF_FFFF);
    send_access(OP_LOAD, 32'hFFFF_FFFF);
    send_access(OP_LOAD, 32'h0000_0000);
    send_access(OP_STORE, 32'h8000_0010);
    send_access(OP_STORE, 32'h8000_0010);
    next_cycle(2);
    send_access(OP_LOAD, 32'h8000_0018);
    send_access(OP_STORE, 32'h0000_0040);
    send_access(OP_LOAD, 32'h0000_0040);
    send_access(OP_STORE, 32'h8000_0100);
    next_cycle(9);
    send_access(OP_LOAD, 32'h8000_0100);
    for (int i = 0; i < 10; i++) send_access(OP_STORE, 32'h9000_0000 + 16 * i);
    send_access(OP_LOAD, 32'h9000_0000);
    send_access(OP_LOAD, 32'h9000_0090);
    clock_now = 32'hFFFF_FFFC;
    send_access(OP_STORE, 32'hA000_0000);
    send_access(OP_LOAD, 32'hA000_0000);
    clock_now = 32'd100;
    drain();

    // Random phases through several latency settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_MEM_LAT, 8'd255); write_reg(REG_HIT_LAT, 8'd255); end
        1: begin write_reg(REG_MEM_LAT, 8'd0);   write_reg(REG_HIT_LAT, 8'd0);   end
        2: begin write_reg(REG_MEM_LAT, 8'($urandom)); write_reg(REG_HIT_LAT, 8'($urandom)); end
        3: begin write_reg(REG_MEM_LAT, 8'hAA);  write_reg(REG_HIT_LAT, 8'h55);  end
        4: begin write_reg(REG_MEM_LAT, 8'h55);  write_reg(REG_HIT_LAT, 8'hAA);  end
        default: begin write_reg(REG_MEM_LAT, 8'd20); write_reg(REG_HIT_LAT, 8'd1); end
      endcase
      if (phase == 2) sink_hold = 1;
      if (phase == 4) sink_free = 1;
      if (phase == 5) sink_free = 0;
      for (int k = 0; k < 127; k++) begin
        // Store then load to the same line, often within the block window.
        if ($urandom_range(0, 2) == 0) begin
          a = any_addr();
          send_access(OP_STORE, a);
          next_cycle($urandom_range(0, 7));
          send_access(OP_LOAD, {a[31:4], 4'($urandom)});
        end else begin
          for (int j = 0; j < 4; j++) lines[j] = any_addr();
          for (int j = 0; j < 2; j++)
            send_access($urandom_range(0, 1) ? OP_STORE : OP_LOAD,
                        lines[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 3) == 0) next_cycle($urandom_range(0, 3));
        if ($urandom_range(0, 99) == 0) next_cycle($urandom_range(1000, 100000));
      end
      // Sender pauses here until every expected result has come.
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
